// ----- rtl/sliding_pattern_match_counter_unit_assert.svh -----
// Assertion macros used by the top RTL file of the pattern match counter.
`ifndef SLIDING_PATTERN_MATCH_COUNTER_UNIT_ASSERT_SVH
`define SLIDING_PATTERN_MATCH_COUNTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SPMC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("spmc assertion failed");

// Next-cycle implication, checked outside reset.
`define SPMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("spmc assertion failed");

`endif

// ----- rtl/spmc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package spmc_pkg;

	localparam int REG_BYTES  = 20;
	localparam int REG_IDX_W  = 5;
	localparam int BYTE_W     = 8;
	localparam int BYTE_IDX_W = 6;
	localparam int OUT_W      = 32;
	localparam int LEN_W      = 5;
	localparam int CFG_DATA_W = 64;
	localparam int CFG_IDX_W  = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_PAT_LO  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_MID = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PAT_HI  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEN     = 2'd3;

	typedef logic [REG_BYTES-1:0][BYTE_W-1:0] pattern_t;

	typedef struct packed {
		logic shift;
		logic flush;
	} win_ctrl_t;

	typedef struct packed {
		logic step;
		logic inc;
		logic flush;
	} cnt_ctrl_t;

	// Pattern bytes past the register file read as zero.
	function automatic logic [BYTE_W-1:0] pattern_byte(pattern_t p,
		logic [BYTE_IDX_W-1:0] k);
		logic [BYTE_W-1:0] b;
		b = '0;
		if (k < BYTE_IDX_W'(REG_BYTES))
			b = p[k[REG_IDX_W-1:0]];
		return b;
	endfunction

endpackage

`default_nettype wire

// ----- rtl/spmc_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spmc_cell (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire spmc_pkg::win_ctrl_t           ctrl,
	input  wire logic [spmc_pkg::BYTE_W-1:0]   byte_in,
	input  wire logic                          valid_in,
	input  wire logic [spmc_pkg::BYTE_W-1:0]   expected,
	input  wire logic                          needed,
	output logic      [spmc_pkg::BYTE_W-1:0]   byte_out,
	output logic                               valid_out,
	output logic                               ok
);

	logic [spmc_pkg::BYTE_W-1:0] byte_q;
	logic                        valid_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift)
			byte_q <= byte_in;
	end

	// Drop the fill mark at the end of a stream.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (ctrl.shift)
			valid_q <= valid_in & ~ctrl.flush;
	end

	assign byte_out  = byte_q;
	assign valid_out = valid_q;
	assign ok        = !needed || (valid_q && (byte_q == expected));

endmodule

`default_nettype wire

// ----- rtl/spmc_counter.sv -----
`timescale 1ns / 1ps
`default_nettype none

module spmc_counter #(
	parameter int COUNT_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire spmc_pkg::cnt_ctrl_t          ctrl,
	output logic      [spmc_pkg::OUT_W-1:0]   shown
);

	logic [COUNT_WIDTH-1:0] count_q;
	logic [COUNT_WIDTH-1:0] count_nxt;

	// Hold at all ones.
	assign count_nxt = (ctrl.inc && (count_q != '1)) ? count_q + 1'b1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			count_q <= '0;
		else if (ctrl.step)
			count_q <= ctrl.flush ? '0 : count_nxt;
	end

	generate
		if (COUNT_WIDTH > spmc_pkg::OUT_W) begin : g_clip
			assign shown = (|count_nxt[COUNT_WIDTH-1:spmc_pkg::OUT_W]) ? '1
				: count_nxt[spmc_pkg::OUT_W-1:0];
		end else begin : g_ext
			assign shown = spmc_pkg::OUT_W'(count_nxt);
		end
	endgenerate

endmodule

`default_nettype wire

// ----- rtl/sliding_pattern_match_counter_unit.sv -----
// Sliding pattern match counter: counts overlapping occurrences of a byte
// pattern (up to MAX_PATTERN_BYTES bytes) in a byte stream.
// Input channel: in_valid / in_stall with data_byte and end_of_stream.
// Output channel: out_valid / out_stall with match_here, match_total,
// bytes_seen and final_result; one result per input byte, in order.
// Configuration: cfg_valid / cfg_ready (always ready), cfg_index selects the
// pattern word (0..2) or the pattern length (3); write only while idle.
// Throughput is one byte per cycle while the receiver does not stall: the
// window is a row of cells that each compare one stored byte in parallel,
// so the hit decision is combinational; out_valid rises in the cycle after
// acceptance. While the receiver stalls, the result register holds and
// in_stall rises as long as the held result is not taken; a byte is taken
// again in the same cycle the held result leaves.
// Reset clears the pattern registers, the window fill marks, both counters
// and the output valid. After a byte marked end_of_stream the window and
// the counters clear; the pattern registers keep their values.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_pattern_match_counter_unit_assert.svh"

module sliding_pattern_match_counter_unit #(
	parameter int MAX_PATTERN_BYTES = 20,
	parameter int COUNT_WIDTH       = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic [spmc_pkg::BYTE_W-1:0]         data_byte,
	input  wire logic                                end_of_stream,
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic                                     match_here,
	output logic      [spmc_pkg::OUT_W-1:0]          match_total,
	output logic      [spmc_pkg::OUT_W-1:0]          bytes_seen,
	output logic                                     final_result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [spmc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [spmc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	localparam int WIN_DEPTH = MAX_PATTERN_BYTES - 1;
	localparam int WIN_N     = (WIN_DEPTH > 0) ? WIN_DEPTH : 1;
	localparam int LW        = $clog2(MAX_PATTERN_BYTES + 1);
	localparam int IW        = spmc_pkg::BYTE_IDX_W + 1;

	spmc_pkg::pattern_t                pat_q;
	logic [spmc_pkg::LEN_W-1:0]        len_q;
	logic [LW-1:0]                     len_eff;

	logic                              accept;
	logic                              hit;
	logic [spmc_pkg::BYTE_W-1:0]       last_expected;
	spmc_pkg::win_ctrl_t               win_ctrl;
	spmc_pkg::cnt_ctrl_t               byte_ctrl;
	spmc_pkg::cnt_ctrl_t               match_ctrl;
	logic [spmc_pkg::OUT_W-1:0]        bytes_nxt;
	logic [spmc_pkg::OUT_W-1:0]        match_nxt;

	logic [WIN_N-1:0][spmc_pkg::BYTE_W-1:0] win_byte;
	logic [WIN_N-1:0]                       win_valid;
	logic [WIN_N-1:0]                       win_ok;

	logic                              out_valid_q;
	logic                              match_here_q;
	logic [spmc_pkg::OUT_W-1:0]        match_total_q;
	logic [spmc_pkg::OUT_W-1:0]        bytes_seen_q;
	logic                              final_result_q;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			len_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				spmc_pkg::CFG_PAT_LO:  pat_q[7:0]   <= cfg_data;
				spmc_pkg::CFG_PAT_MID: pat_q[15:8]  <= cfg_data;
				spmc_pkg::CFG_PAT_HI:  pat_q[19:16] <= cfg_data[31:0];
				spmc_pkg::CFG_LEN:     len_q        <= cfg_data[spmc_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Clamp the length to the window capacity.
	assign len_eff = (IW'(len_q) > IW'(MAX_PATTERN_BYTES)) ? LW'(MAX_PATTERN_BYTES)
		: LW'(len_q);

	assign accept = in_valid && !in_stall;
	assign in_stall = out_valid_q && out_stall;

	assign win_ctrl.shift = accept;
	assign win_ctrl.flush = end_of_stream;

	// Window: cell i holds the byte i+1 places back and checks it against
	// pattern byte len-2-i.
	generate
		if (WIN_DEPTH > 0) begin : g_row
			for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_win
				logic                        needed;
				logic [spmc_pkg::BYTE_W-1:0] expected;
				logic [spmc_pkg::BYTE_W-1:0] prev_byte;
				logic                        prev_valid;

				assign needed   = IW'(len_eff) >= IW'(i + 2);
				assign expected = spmc_pkg::pattern_byte(pat_q,
					spmc_pkg::BYTE_IDX_W'(IW'(len_eff) - IW'(i + 2)));

				if (i == 0) begin : g_head
					assign prev_byte  = data_byte;
					assign prev_valid = 1'b1;
				end else begin : g_link
					assign prev_byte  = win_byte[i-1];
					assign prev_valid = win_valid[i-1];
				end

				spmc_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctrl      (win_ctrl),
					.byte_in   (prev_byte),
					.valid_in  (prev_valid),
					.expected  (expected),
					.needed    (needed),
					.byte_out  (win_byte[i]),
					.valid_out (win_valid[i]),
					.ok        (win_ok[i])
				);
			end
		end else begin : g_empty
			assign win_byte  = '0;
			assign win_valid = '0;
			assign win_ok    = '1;
		end
	endgenerate

	assign last_expected = spmc_pkg::pattern_byte(pat_q,
		spmc_pkg::BYTE_IDX_W'(IW'(len_eff) - IW'(1)));

	assign hit = (len_eff == '0) || ((data_byte == last_expected) && (&win_ok));

	assign byte_ctrl.step  = accept;
	assign byte_ctrl.inc   = 1'b1;
	assign byte_ctrl.flush = end_of_stream;

	assign match_ctrl.step  = accept;
	assign match_ctrl.inc   = hit;
	assign match_ctrl.flush = end_of_stream;

	spmc_counter #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_byte_count (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (byte_ctrl),
		.shown  (bytes_nxt)
	);

	spmc_counter #(
		.COUNT_WIDTH (COUNT_WIDTH)
	) u_match_count (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (match_ctrl),
		.shown  (match_nxt)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (accept)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			match_here_q   <= hit;
			match_total_q  <= match_nxt;
			bytes_seen_q   <= bytes_nxt;
			final_result_q <= end_of_stream;
		end
	end

	assign out_valid    = out_valid_q;
	assign match_here   = match_here_q;
	assign match_total  = match_total_q;
	assign bytes_seen   = bytes_seen_q;
	assign final_result = final_result_q;

	`SPMC_ASSERT_NEXT(a_accept_gives_result, clk, arst_n, accept, out_valid)
	`SPMC_ASSERT_NEXT(a_zero_len_hits, clk, arst_n, accept && (len_eff == '0), match_here)
	`SPMC_ASSERT_NEXT(a_last_flags, clk, arst_n, accept && end_of_stream, final_result)
	`SPMC_ASSERT_NEXT(a_last_clears_window, clk, arst_n, accept && end_of_stream, win_valid == '0)
	`SPMC_ASSERT_NOW(a_hit_counts, clk, arst_n, out_valid && match_here, match_total != '0)

endmodule

`default_nettype wire
